// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define NFBLR_ASSERT_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("nfblr assertion failed");

// antecedent in one cycle implies consequent in the next
`define NFBLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nfblr assertion failed");

`endif

// ===== rtl/nfblr_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`default_nettype none

package nfblr_pkg;

    localparam int PANEL_WIDTH  = 176;
    localparam int PANEL_HEIGHT = 176;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 1) / 2;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int LINE_BYTES   = ROW_BYTES + 4;

    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int POS_W     = $clog2(LINE_BYTES);
    localparam int ROW_W     = $clog2(PANEL_HEIGHT + 1);
    localparam int CFG_IDX_W = 3;

    // input modes
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_BLINK = 2'd3;

    // blink kinds
    localparam logic [1:0] BLINK_NONE    = 2'd0;
    localparam logic [1:0] BLINK_WHITE   = 2'd1;
    localparam logic [1:0] BLINK_BLACK   = 2'd2;
    localparam logic [1:0] BLINK_INVERSE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_CLEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_UPDATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_WHITE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_BLACK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSION   = 3'd6;

    // register reset values
    localparam logic [3:0] RST_BACKGROUND  = 4'd14;
    localparam logic [7:0] RST_UPDATE      = 8'd144;
    localparam logic [7:0] RST_ALL_CLEAR   = 8'd32;
    localparam logic [7:0] RST_NO_UPDATE   = 8'd0;
    localparam logic [7:0] RST_BLINK_WHITE = 8'd24;
    localparam logic [7:0] RST_BLINK_BLACK = 8'd16;
    localparam logic [7:0] RST_INVERSION   = 8'd20;

    // which byte the output register loads
    typedef enum logic [1:0] {
        OUT_TICK,
        OUT_CLEAR,
        OUT_BLINK,
        OUT_TAIL
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     draw_wr;
        logic     push;
        t_out_sel out_sel;
        logic     fill_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_last;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/nfblr_ctrl.sv =====
// sequencing state machine for draw, refresh, clear and blink items
`default_nettype none

`include "assert_macros.svh"

module nfblr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_mode,
    input  wire nfblr_pkg::t_status i_status,
    output nfblr_pkg::t_cmd        o_cmd,
    output logic                   o_in_stall
);
    import nfblr_pkg::*;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_DRAW,
        S_TICK,
        S_HEAD,
        S_TAIL
    } t_state;

    t_state   r_state, n_state;
    logic     r_stall, n_stall;
    t_out_sel r_head_sel, n_head_sel;
    logic     r_do_fill, n_do_fill;
    logic     accept;

    assign accept     = i_in_valid && !r_stall;
    assign o_in_stall = r_stall;

    always_comb begin
        n_state    = r_state;
        n_head_sel = r_head_sel;
        n_do_fill  = r_do_fill;
        o_cmd      = '0;
        o_cmd.out_sel = OUT_TICK;
        unique case (r_state)
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_mode)
                        MODE_DRAW: n_state = S_DRAW;
                        MODE_TICK: n_state = S_TICK;
                        MODE_CLEAR: begin
                            n_state    = S_HEAD;
                            n_head_sel = OUT_CLEAR;
                            n_do_fill  = 1'b1;
                        end
                        default: begin
                            n_state    = S_HEAD;
                            n_head_sel = OUT_BLINK;
                            n_do_fill  = 1'b0;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                o_cmd.draw_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_TICK: begin
                if (i_status.out_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.out_sel = OUT_TICK;
                    n_state       = S_IDLE;
                end
            end
            S_HEAD: begin
                if (i_status.out_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.out_sel = r_head_sel;
                    n_state       = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.out_sel = OUT_TAIL;
                    n_state       = r_do_fill ? S_FILL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_stall    <= 1'b1;
            r_head_sel <= OUT_BLINK;
            r_do_fill  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_stall    <= n_stall;
            r_head_sel <= n_head_sel;
            r_do_fill  <= n_do_fill;
        end
    end

    `NFBLR_ASSERT_NEXT(a_clear_heads_to_fill, i_clk, i_rst_n,
        accept && (i_mode == MODE_CLEAR), (r_state == S_HEAD) && r_do_fill)
    `NFBLR_ASSERT_HOLDS(a_push_needs_room, i_clk, i_rst_n,
        !o_cmd.push || i_status.out_free)
    `NFBLR_ASSERT_NEXT(a_draw_one_cycle, i_clk, i_rst_n,
        r_state == S_DRAW, !r_stall)

endmodule

`default_nettype wire

// ===== rtl/nfblr_datapath.sv =====
// frame store, refresh counters, configuration registers and output register
`default_nettype none

`include "assert_macros.svh"

module nfblr_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire nfblr_pkg::t_cmd                 i_cmd,
    output nfblr_pkg::t_status                   o_status,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [7:0]                      i_pixel_x,
    input  wire logic [7:0]                      i_pixel_y,
    input  wire logic [3:0]                      i_pixel_color,
    input  wire logic [1:0]                      i_blink_kind,
    input  wire logic                            i_cfg_valid,
    input  wire logic [nfblr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_packet_end,
    output logic                                 o_frame_done,
    output logic                                 o_extcom_level
);
    import nfblr_pkg::*;

    logic [7:0] mem [STORE_BYTES];

    // configuration
    logic [3:0] r_background;
    logic [7:0] r_cmd_update, r_cmd_all_clear, r_cmd_no_update;
    logic [7:0] r_cmd_blink_white, r_cmd_blink_black, r_cmd_inversion;

    // captured item
    logic [ADDR_W-1:0] r_pix_addr;
    logic              r_on_panel;
    logic              r_x_lsb;
    logic [3:0]        r_color;
    logic [1:0]        r_kind;

    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_fill_addr;
    logic [7:0]        r_fill_pair;
    logic [ROW_W-1:0]  r_row;
    logic [POS_W-1:0]  r_pos;
    logic              r_extcom;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_pend, r_out_fdone, r_out_ext;

    logic [ADDR_W-1:0] pix_addr, tick_addr, rd_addr;
    logic              on_panel, data_pos, pos_last, row_last, frame_end;
    logic [7:0]        tick_byte, blink_byte, merged;
    logic              out_free;

    assign on_panel = (i_pixel_x < 8'(PANEL_WIDTH)) && (i_pixel_y < 8'(PANEL_HEIGHT));
    assign pix_addr = ADDR_W'(ADDR_W'(i_pixel_y) * ADDR_W'(ROW_BYTES))
                    + ADDR_W'(i_pixel_x >> 1);

    assign data_pos  = (r_pos >= POS_W'(2)) && (r_pos < POS_W'(ROW_BYTES + 2));
    assign tick_addr = data_pos
        ? ADDR_W'(ADDR_W'(r_row) * ADDR_W'(ROW_BYTES)) + ADDR_W'(r_pos) - ADDR_W'(2)
        : '0;
    assign rd_addr   = (i_mode == MODE_DRAW) ? pix_addr : tick_addr;

    assign pos_last  = (r_pos == POS_W'(LINE_BYTES - 1));
    assign row_last  = (r_row == ROW_W'(PANEL_HEIGHT - 1));
    assign frame_end = pos_last && row_last;

    assign merged = r_x_lsb ? {r_rd_data[7:4], r_color} : {r_color, r_rd_data[3:0]};

    always_comb begin
        priority if (r_pos == POS_W'(0)) begin
            tick_byte = r_cmd_update;
        end else if (r_pos == POS_W'(1)) begin
            tick_byte = 8'(r_row) + 8'd1;
        end else if (data_pos) begin
            tick_byte = r_rd_data;
        end else begin
            tick_byte = 8'h00;
        end
    end

    always_comb begin
        unique case (r_kind)
            BLINK_WHITE:   blink_byte = r_cmd_blink_white;
            BLINK_BLACK:   blink_byte = r_cmd_blink_black;
            BLINK_INVERSE: blink_byte = r_cmd_inversion;
            default:       blink_byte = r_cmd_no_update;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_status.out_free  = out_free;
    assign o_status.fill_last = (r_fill_addr == ADDR_W'(STORE_BYTES - 1));

    // single-port style store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step) begin
            mem[r_fill_addr] <= r_fill_pair;
        end else if (i_cmd.draw_wr && r_on_panel) begin
            mem[r_pix_addr] <= merged;
        end
        if (i_cmd.capture) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // payload capture and output register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix_addr <= pix_addr;
            r_on_panel <= on_panel;
            r_x_lsb    <= i_pixel_x[0];
            r_color    <= i_pixel_color;
            r_kind     <= i_blink_kind;
        end
        if (i_cmd.push) begin
            unique case (i_cmd.out_sel)
                OUT_TICK: begin
                    r_out_byte  <= tick_byte;
                    r_out_pend  <= pos_last;
                    r_out_fdone <= frame_end;
                    // last byte of the frame already shows the toggled level
                    r_out_ext   <= frame_end ? ~r_extcom : r_extcom;
                end
                OUT_CLEAR: begin
                    r_out_byte  <= r_cmd_all_clear;
                    r_out_pend  <= 1'b0;
                    r_out_fdone <= 1'b0;
                    r_out_ext   <= r_extcom;
                end
                OUT_BLINK: begin
                    r_out_byte  <= blink_byte;
                    r_out_pend  <= 1'b0;
                    r_out_fdone <= 1'b0;
                    r_out_ext   <= r_extcom;
                end
                default: begin
                    r_out_byte  <= 8'h00;
                    r_out_pend  <= 1'b1;
                    r_out_fdone <= 1'b0;
                    r_out_ext   <= r_extcom;
                end
            endcase
        end
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_background      <= RST_BACKGROUND;
            r_cmd_update      <= RST_UPDATE;
            r_cmd_all_clear   <= RST_ALL_CLEAR;
            r_cmd_no_update   <= RST_NO_UPDATE;
            r_cmd_blink_white <= RST_BLINK_WHITE;
            r_cmd_blink_black <= RST_BLINK_BLACK;
            r_cmd_inversion   <= RST_INVERSION;
            r_fill_addr       <= '0;
            r_fill_pair       <= 8'h00;
            r_row             <= '0;
            r_pos             <= '0;
            r_extcom          <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BACKGROUND:  r_background      <= i_cfg_data[3:0];
                    CFG_UPDATE:      r_cmd_update      <= i_cfg_data;
                    CFG_ALL_CLEAR:   r_cmd_all_clear   <= i_cfg_data;
                    CFG_NO_UPDATE:   r_cmd_no_update   <= i_cfg_data;
                    CFG_BLINK_WHITE: r_cmd_blink_white <= i_cfg_data;
                    CFG_BLINK_BLACK: r_cmd_blink_black <= i_cfg_data;
                    CFG_INVERSION:   r_cmd_inversion   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.fill_step) begin
                r_fill_addr <= o_status.fill_last ? '0 : r_fill_addr + ADDR_W'(1);
            end

            // clear and blink abandon the refresh in progress
            if (i_cmd.capture && (i_mode == MODE_CLEAR || i_mode == MODE_BLINK)) begin
                r_row <= '0;
                r_pos <= '0;
            end
            if (i_cmd.capture && i_mode == MODE_CLEAR) begin
                r_fill_pair <= {r_background, r_background};
            end

            if (i_cmd.push && i_cmd.out_sel == OUT_TICK) begin
                r_pos <= pos_last ? '0 : r_pos + POS_W'(1);
                if (pos_last) begin
                    r_row <= row_last ? '0 : r_row + ROW_W'(1);
                end
                if (frame_end) begin
                    r_extcom <= ~r_extcom;
                end
            end
            if (i_cmd.push && i_cmd.out_sel == OUT_CLEAR) begin
                r_extcom <= ~r_extcom;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_packet_end   = r_out_pend;
    assign o_frame_done   = r_out_fdone;
    assign o_extcom_level = r_out_ext;

    `NFBLR_ASSERT_HOLDS(a_pos_in_line, i_clk, i_rst_n, r_pos < POS_W'(LINE_BYTES))
    `NFBLR_ASSERT_HOLDS(a_row_in_panel, i_clk, i_rst_n, r_row < ROW_W'(PANEL_HEIGHT))
    `NFBLR_ASSERT_HOLDS(a_fill_only_in_sweep, i_clk, i_rst_n,
        (r_fill_addr == '0) || $past(i_cmd.fill_step))

endmodule

`default_nettype wire

// ===== rtl/nibble_framebuffer_line_refresher.sv =====
// top level: 4-bit-per-pixel frame buffer with line-update byte stream
//
// input channel (i_in_valid / o_in_stall): one beat is a draw, a refresh
// tick, a clear or a blink request, selected by i_mode
// output channel (o_out_valid / i_out_stall): one beat is one panel byte
// with its end-of-packet, end-of-frame and extcomin flags
// configuration channel (i_cfg_valid / o_cfg_ready): always ready, index
// selects one of seven registers, indexes beyond the list are dropped
// draw: read of the store byte, then the nibble write back
// refresh tick: the store byte is read into a register, then loaded into
// the output register once it is free; blink: two bytes out, then idle
// clear: two bytes out, then a sweep of the store writing the background
// pair, one byte a cycle, over all 15488 store bytes, during which no beat
// is taken; after reset the same sweep writes zeros, so the block stalls
// its input until the sweep ends; configuration writes are taken throughout
// one item is worked on at a time; the steps above are set by the single
// store port and the sweep counter
// a stalled output holds its byte; the next item is still accepted while a
// finished byte waits in the output register
`default_nettype none

module nibble_framebuffer_line_refresher (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [7:0]                      i_pixel_x,
    input  wire logic [7:0]                      i_pixel_y,
    input  wire logic [3:0]                      i_pixel_color,
    input  wire logic [1:0]                      i_blink_kind,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [nfblr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    // byte stream
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_packet_end,
    output logic                                 o_frame_done,
    output logic                                 o_extcom_level
);
    import nfblr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // registers are plain flops, no reason to refuse a write
    assign o_cfg_ready = 1'b1;

    // sequencer: decides per item which store and output steps run
    nfblr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // store, counters, registers and the output register
    nfblr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_color  (i_pixel_color),
        .i_blink_kind   (i_blink_kind),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_packet_end   (o_packet_end),
        .o_frame_done   (o_frame_done),
        .o_extcom_level (o_extcom_level)
    );

endmodule

`default_nettype wire

// ===== dv/nibble_framebuffer_line_refresher_tb.sv =====
// self-checking testbench for the nibble frame buffer line refresher
`timescale 1ns / 100ps

module nibble_framebuffer_line_refresher_tb;

    import nfblr_pkg::*;

    // index past the end of the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    // longest stretch with no beat on any channel: reset or clear sweep plus settling
    localparam int STUCK_LIMIT = 4 * STORE_BYTES;
    localparam int DIR_ROWS    = 24;
    localparam int PHASE_ITEMS = 100;

    // one input beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] color;
        logic [1:0] kind;
    } panel_req_t;

    // one output beat
    typedef struct packed {
        logic [7:0] data;
        logic       pend;
        logic       fdone;
        logic       ext;
    } line_byte_t;

    // directed row: n_typed of zero means the mirror supplies the bytes
    typedef struct packed {
        panel_req_t req;
        logic [1:0] n_typed;
        line_byte_t b0;
        line_byte_t b1;
    } step_row_t;

    localparam line_byte_t NO_BYTE = '0;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [1:0]           i_mode         = MODE_DRAW;
    logic [7:0]           i_pixel_x      = 8'd0;
    logic [7:0]           i_pixel_y      = 8'd0;
    logic [3:0]           i_pixel_color  = 4'd0;
    logic [1:0]           i_blink_kind   = BLINK_NONE;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_BACKGROUND;
    logic [7:0]           i_cfg_data     = 8'd0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_cfg_ready;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_packet_end;
    logic                 o_frame_done;
    logic                 o_extcom_level;

    nibble_framebuffer_line_refresher uut (.*);

    // mirror of the panel state and registers
    logic [7:0] fb_mem [STORE_BYTES];
    logic [7:0] ln_row;
    logic [7:0] ln_pos;
    logic       ext_level;
    logic [3:0] bg_color;
    logic [7:0] cmd_upd, cmd_clr, cmd_none, cmd_white, cmd_black, cmd_inv;

    line_byte_t bytes_due [$];
    line_byte_t step_out [2];
    int         step_cnt;
    line_byte_t due;
    step_row_t  steps [DIR_ROWS];

    int gap_pct     = 0;
    int stall_pct   = 0;
    int errors      = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int bytes_seen  = 0;
    int clears_sent = 0;
    bit sweep_owed  = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // works out the bytes one accepted beat produces and moves the mirror on
    task automatic advance_panel(input panel_req_t r);
        int unsigned addr;
        int unsigned pos_n;
        int unsigned row_n;
        logic [7:0]  b;
        logic        pend;
        logic        fd;
        step_cnt = 0;
        case (r.mode)
            MODE_DRAW: begin
                // off-panel pixels leave the store alone
                if (r.x < PANEL_WIDTH && r.y < PANEL_HEIGHT) begin
                    addr = r.y * ROW_BYTES + r.x / 2;
                    if (r.x[0] == 1'b0)
                        fb_mem[addr][7:4] = r.color;
                    else
                        fb_mem[addr][3:0] = r.color;
                end
            end
            MODE_TICK: begin
                row_n = 32'(ln_row);
                pos_n = 32'(ln_pos);
                if (pos_n == 0)
                    b = cmd_upd;
                else if (pos_n == 1)
                    b = ln_row + 8'd1;
                else if (pos_n < ROW_BYTES + 2)
                    b = fb_mem[row_n * ROW_BYTES + pos_n - 2];
                else
                    b = 8'h00;
                pend = 1'b0;
                fd   = 1'b0;
                pos_n++;
                if (pos_n == LINE_BYTES) begin
                    // end of line packet, and end of frame on the last row
                    pend  = 1'b1;
                    pos_n = 0;
                    row_n++;
                    if (row_n == PANEL_HEIGHT) begin
                        row_n     = 0;
                        fd        = 1'b1;
                        ext_level = ~ext_level;
                    end
                end
                ln_pos      = pos_n[7:0];
                ln_row      = row_n[7:0];
                step_out[0] = '{b, pend, fd, ext_level};
                step_cnt    = 1;
            end
            MODE_CLEAR: begin
                // any refresh in progress is dropped
                ln_row = 8'd0;
                ln_pos = 8'd0;
                for (int a = 0; a < STORE_BYTES; a++)
                    fb_mem[a] = {bg_color, bg_color};
                // command byte shows the old level, the zero byte the toggled one
                step_out[0] = '{cmd_clr, 1'b0, 1'b0, ext_level};
                ext_level   = ~ext_level;
                step_out[1] = '{8'h00, 1'b1, 1'b0, ext_level};
                step_cnt    = 2;
            end
            default: begin
                ln_row = 8'd0;
                ln_pos = 8'd0;
                case (r.kind)
                    BLINK_WHITE:   b = cmd_white;
                    BLINK_BLACK:   b = cmd_black;
                    BLINK_INVERSE: b = cmd_inv;
                    default:       b = cmd_none;
                endcase
                step_out[0] = '{b, 1'b0, 1'b0, ext_level};
                step_out[1] = '{8'h00, 1'b1, 1'b0, ext_level};
                step_cnt    = 2;
            end
        endcase
    endtask

    // offers one beat, waits for it to be taken, then queues its bytes
    task automatic send_req(input panel_req_t r, input int n_typed,
                            input line_byte_t t0, input line_byte_t t1);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= r.mode;
        i_pixel_x     <= r.x;
        i_pixel_y     <= r.y;
        i_pixel_color <= r.color;
        i_blink_kind  <= r.kind;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        advance_panel(r);
        if (r.mode == MODE_CLEAR) begin
            sweep_owed = 1'b1;
            clears_sent++;
        end
        if (n_typed == 0) begin
            for (int k = 0; k < step_cnt; k++)
                bytes_due.push_back(step_out[k]);
        end else begin
            bytes_due.push_back(t0);
            if (n_typed > 1)
                bytes_due.push_back(t1);
        end
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_BACKGROUND:  bg_color  = data[3:0];
            CFG_UPDATE:      cmd_upd   = data;
            CFG_ALL_CLEAR:   cmd_clr   = data;
            CFG_NO_UPDATE:   cmd_none  = data;
            CFG_BLINK_WHITE: cmd_white = data;
            CFG_BLINK_BLACK: cmd_black = data;
            CFG_INVERSION:   cmd_inv   = data;
            default: ;
        endcase
    endtask

    // full register set, plus a write to the unused index
    task automatic program_regs(input logic [3:0] bg, input logic [7:0] upd,
                                input logic [7:0] clr, input logic [7:0] none,
                                input logic [7:0] white, input logic [7:0] black,
                                input logic [7:0] inv);
        logic [3:0] hi_junk;
        logic [7:0] junk;
        hi_junk = 4'($urandom_range(15));
        junk    = 8'($urandom_range(255));
        cfg_write(CFG_BACKGROUND, {hi_junk, bg});
        cfg_write(CFG_UPDATE, upd);
        cfg_write(CFG_ALL_CLEAR, clr);
        cfg_write(CFG_NO_UPDATE, none);
        cfg_write(CFG_BLINK_WHITE, white);
        cfg_write(CFG_BLINK_BLACK, black);
        cfg_write(CFG_INVERSION, inv);
        cfg_write(CFG_UNUSED, junk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random register set
    task automatic program_random();
        program_regs(4'($urandom_range(15)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    // drain the byte stream, then let any draw or clear sweep finish
    task automatic settle();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (bytes_due.size() != 0);
        repeat (sweep_owed ? STORE_BYTES + 16 : 8)
            @(posedge i_clk);
        sweep_owed = 1'b0;
    endtask

    function automatic panel_req_t rand_req(input logic [1:0] mode);
        panel_req_t r;
        r.mode  = mode;
        r.x     = 8'($urandom_range(255));
        r.y     = 8'($urandom_range(255));
        r.color = 4'($urandom_range(15));
        r.kind  = 2'($urandom_range(3));
        // most draws land on panel, many on the first rows the refresh reaches
        if (mode == MODE_DRAW && $urandom_range(9) < 8) begin
            r.x = 8'($urandom_range(PANEL_WIDTH - 1));
            r.y = 8'($urandom_range(1) ? $urandom_range(2)
                                       : $urandom_range(PANEL_HEIGHT - 1));
        end
        return r;
    endfunction

    // bursts of ticks with draws mixed in, draw runs, the odd blink or clear
    task automatic random_run(input int n_items);
        int start;
        int pick;
        int burst;
        bit drained;
        start   = items_sent;
        drained = 1'b0;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                burst = $urandom_range(1, 100);
                if (burst > n_items - (items_sent - start))
                    burst = n_items - (items_sent - start);
                repeat (burst)
                    send_req(rand_req($urandom_range(4) == 0 ? MODE_DRAW : MODE_TICK),
                             0, NO_BYTE, NO_BYTE);
            end else if (pick < 80) begin
                burst = $urandom_range(1, 8);
                if (burst > n_items - (items_sent - start))
                    burst = n_items - (items_sent - start);
                repeat (burst)
                    send_req(rand_req(MODE_DRAW), 0, NO_BYTE, NO_BYTE);
            end else if (pick < 95) begin
                send_req(rand_req(MODE_BLINK), 0, NO_BYTE, NO_BYTE);
            end else begin
                send_req(rand_req(MODE_CLEAR), 0, NO_BYTE, NO_BYTE);
            end
            // hold the sender off once until the stream has run dry
            if (!drained && items_sent - start >= n_items / 2) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                do
                    @(posedge i_clk);
                while (bytes_due.size() != 0);
            end
        end
    endtask

    function automatic line_byte_t lb(input logic [7:0] d, input int p,
                                      input int f, input int e);
        return '{d, 1'(p), 1'(f), 1'(e)};
    endfunction

    function automatic step_row_t mk_step(input logic [1:0] mode, input logic [7:0] x,
                                          input logic [7:0] y, input logic [3:0] color,
                                          input logic [1:0] kind, input int n,
                                          input line_byte_t b0, input line_byte_t b1);
        return '{'{mode, x, y, color, kind}, 2'(n), b0, b1};
    endfunction

    function automatic void cmp_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
            errors++;
        end
    endfunction

    // byte stream checker, receiver stall and idle counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: byte with nothing due, expected none, got %02h",
                             $time, o_out_byte);
                    errors++;
                end else begin
                    due = bytes_due.pop_front();
                    cmp_field("out_byte", due.data, o_out_byte);
                    cmp_field("packet_end", {7'd0, due.pend}, {7'd0, o_packet_end});
                    cmp_field("frame_done", {7'd0, due.fdone}, {7'd0, o_frame_done});
                    cmp_field("extcom_level", {7'd0, due.ext}, {7'd0, o_extcom_level});
                end
                bytes_seen++;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (idle_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("%0t: no beat for %0d cycles, %0d bytes still due",
                 $time, STUCK_LIMIT, bytes_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        for (int a = 0; a < STORE_BYTES; a++)
            fb_mem[a] = 8'h00;
        ln_row    = 8'd0;
        ln_pos    = 8'd0;
        ext_level = 1'b0;
        bg_color  = RST_BACKGROUND;
        cmd_upd   = RST_UPDATE;
        cmd_clr   = RST_ALL_CLEAR;
        cmd_none  = RST_NO_UPDATE;
        cmd_white = RST_BLINK_WHITE;
        cmd_black = RST_BLINK_BLACK;
        cmd_inv   = RST_INVERSION;

        // directed rows, run at reset register values on a zeroed store
        steps[0]  = mk_step(MODE_BLINK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 2,
                            lb(8'd0, 0, 0, 0), lb(8'd0, 1, 0, 0));
        steps[1]  = mk_step(MODE_BLINK, 8'd0, 8'd0, 4'd0, BLINK_WHITE, 2,
                            lb(8'd24, 0, 0, 0), lb(8'd0, 1, 0, 0));
        steps[2]  = mk_step(MODE_BLINK, 8'd0, 8'd0, 4'd0, BLINK_BLACK, 2,
                            lb(8'd16, 0, 0, 0), lb(8'd0, 1, 0, 0));
        steps[3]  = mk_step(MODE_BLINK, 8'd0, 8'd0, 4'd0, BLINK_INVERSE, 2,
                            lb(8'd20, 0, 0, 0), lb(8'd0, 1, 0, 0));
        steps[4]  = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd144, 0, 0, 0), NO_BYTE);
        steps[5]  = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd1, 0, 0, 0), NO_BYTE);
        steps[6]  = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd0, 0, 0, 0), NO_BYTE);
        // nibble placement, the far corner and pixels just off the panel
        steps[7]  = mk_step(MODE_DRAW, 8'd0, 8'd0, 4'd15, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        steps[8]  = mk_step(MODE_DRAW, 8'd1, 8'd0, 4'd10, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        steps[9]  = mk_step(MODE_DRAW, 8'd175, 8'd175, 4'd15, BLINK_NONE, 0,
                            NO_BYTE, NO_BYTE);
        steps[10] = mk_step(MODE_DRAW, 8'd174, 8'd175, 4'd0, BLINK_NONE, 0,
                            NO_BYTE, NO_BYTE);
        steps[11] = mk_step(MODE_DRAW, 8'd176, 8'd0, 4'd15, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        steps[12] = mk_step(MODE_DRAW, 8'd0, 8'd176, 4'd15, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        steps[13] = mk_step(MODE_DRAW, 8'd255, 8'd255, 4'd15, BLINK_INVERSE, 0,
                            NO_BYTE, NO_BYTE);
        steps[14] = mk_step(MODE_TICK, 8'd255, 8'd255, 4'd15, BLINK_INVERSE, 0,
                            NO_BYTE, NO_BYTE);
        // blink mid-line drops the refresh back to the start of the frame
        steps[15] = mk_step(MODE_BLINK, 8'd255, 8'd255, 4'd15, BLINK_INVERSE, 2,
                            lb(8'd20, 0, 0, 0), lb(8'd0, 1, 0, 0));
        steps[16] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd144, 0, 0, 0), NO_BYTE);
        steps[17] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd1, 0, 0, 0), NO_BYTE);
        steps[18] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        // clear mid-line, level toggles on the zero byte
        steps[19] = mk_step(MODE_CLEAR, 8'd0, 8'd0, 4'd0, BLINK_NONE, 2,
                            lb(8'd32, 0, 0, 0), lb(8'd0, 1, 0, 1));
        steps[20] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd144, 0, 0, 1), NO_BYTE);
        steps[21] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 1,
                            lb(8'd1, 0, 0, 1), NO_BYTE);
        steps[22] = mk_step(MODE_TICK, 8'd0, 8'd0, 4'd0, BLINK_NONE, 0, NO_BYTE, NO_BYTE);
        steps[23] = mk_step(MODE_CLEAR, 8'd255, 8'd255, 4'd15, BLINK_INVERSE, 2,
                            lb(8'd32, 0, 0, 1), lb(8'd0, 1, 0, 0));

        repeat (5)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block sweeps its store after reset, the first beat waits on it
        for (int i = 0; i < DIR_ROWS; i++)
            send_req(steps[i].req, steps[i].n_typed, steps[i].b0, steps[i].b1);
        settle();

        // random registers, no idling
        program_random();
        gap_pct   = 0;
        stall_pct = 0;
        random_run(PHASE_ITEMS);
        settle();

        // all registers at the bottom, sparse sender
        program_regs(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        gap_pct   = 69;
        stall_pct = 0;
        random_run(PHASE_ITEMS);
        settle();

        // all registers at the top, sluggish receiver
        program_regs(4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        gap_pct   = 0;
        stall_pct = 69;
        random_run(PHASE_ITEMS);
        settle();

        // random registers, both sides idling
        program_random();
        gap_pct   = 31;
        stall_pct = 31;
        random_run(PHASE_ITEMS);
        settle();

        program_random();
        gap_pct   = 31;
        stall_pct = 31;
        random_run(PHASE_ITEMS);
        settle();
        stall_pct = 0;
        repeat (32)
            @(posedge i_clk);

        $display("covered %0d beats in, %0d bytes out, %0d clears",
                 items_sent, bytes_seen, clears_sent);
        $display("over six register settings and four idling patterns, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== nibble_framebuffer_line_refresher.f =====
+incdir+rtl
rtl/nfblr_pkg.sv
rtl/nfblr_ctrl.sv
rtl/nfblr_datapath.sv
rtl/nibble_framebuffer_line_refresher.sv
dv/nibble_framebuffer_line_refresher_tb.sv
